// ===== hdl/evih_pkg.sv =====
// Package for the event interval histogram.
// Holds sizes, field widths and the stream payload layouts; no dependencies.
`default_nettype none

package evih_pkg;

  localparam int BIN_W      = 11;
  localparam int NUM_BINS   = 1 << BIN_W;
  localparam int COUNT_BITS = 16;

  localparam logic [BIN_W-1:0]      TOP_BIN   = {BIN_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic                  is_read;
    logic                  is_event;
    logic [BIN_W-1:0]      addr;
    logic [BIN_W-1:0]      longest;
    logic [BIN_W-1:0]      shortest;
    logic [COUNT_BITS-1:0] total;
  } evih_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_count;
    logic [BIN_W-1:0]      closed_interval;
    logic                  interval_closed;
    logic [BIN_W-1:0]      longest;
    logic [BIN_W-1:0]      shortest;
    logic [COUNT_BITS-1:0] event_total;
  } evih_result_t;

endpackage

`default_nettype wire

// ===== hdl/evih_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module evih_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/event_interval_histogram_top.sv =====
// Event interval histogram, top level.
// Depends on evih_pkg and evih_ram.
//
// Usage:
//   in_*  : one transaction per sample or bin read. in_tuser is the op
//           (0 = stream sample, 1 = read bin); in_tdata carries event_req and bin.
//   out_* : exactly one result transaction per input transaction, in order.
//           out_tuser is interval_closed; out_tdata carries the counts.
// Throughput is one transaction per cycle while out_tready stays high. Each
// transaction passes through the histogram memory read into the middle stage,
// then through the increment and write-back into the output register. An event
// that hits the bin being written by the item ahead gets the forwarded count.
// After reset the histogram memory is swept to zero, one bin per cycle, across
// all 2048 bins; in_tready stays low during that sweep. When the receiver
// stalls, the output register holds, the middle stage fills, and in_tready
// drops; no transaction is lost or repeated.
`default_nettype none

module event_interval_histogram_top
  import evih_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [0] event_req, [11:1] bin, rest zero
  input  wire logic                  in_tuser,   // [0] op
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [15:0] bin_count, [26:16] closed_interval,
                                                 // [37:27] longest, [48:38] shortest,
                                                 // [64:49] event_total, rest zero
  output logic                       out_tuser   // [0] interval_closed
);

  logic                  clearing_r;
  logic [BIN_W-1:0]      clr_addr_r;
  logic [BIN_W-1:0]      gap_r, gap_nxt;
  logic [BIN_W-1:0]      longest_r, longest_nxt;
  logic [BIN_W-1:0]      shortest_r, shortest_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;

  logic                  s1_valid_r;
  evih_item_t            s1_r, s1_nxt;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  out_valid_r;
  evih_result_t          out_r, out_nxt;

  logic                  in_fire, s1_adv, evt_wr;
  logic                  in_event, in_read;
  logic [BIN_W-1:0]      in_bin, in_addr;
  logic [COUNT_BITS-1:0] rd_data, cur_count, inc_count;
  logic                  ram_we;
  logic [BIN_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  assign in_read  = (in_tuser == OP_READ);
  assign in_event = in_tdata[0];
  assign in_bin   = in_tdata[BIN_W:1];
  assign in_addr  = in_read ? in_bin : gap_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  // Stream statistics advance when a sample is accepted; bin reads leave them unchanged
  always_comb begin
    gap_nxt      = gap_r;
    longest_nxt  = longest_r;
    shortest_nxt = shortest_r;
    total_nxt    = total_r;
    if (in_fire && !in_read) begin
      if (in_event) begin
        gap_nxt = '0;
        if (gap_r > longest_r) begin
          longest_nxt = gap_r;
        end
        if (gap_r < shortest_r) begin
          shortest_nxt = gap_r;
        end
        if (total_r != COUNT_MAX) begin
          total_nxt = total_r + 1'b1;
        end
      end else if (gap_r != TOP_BIN) begin
        gap_nxt = gap_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_nxt.is_read  = in_read;
    s1_nxt.is_event = !in_read && in_event;
    s1_nxt.addr     = in_addr;
    s1_nxt.longest  = longest_nxt;
    s1_nxt.shortest = shortest_nxt;
    s1_nxt.total    = total_nxt;
  end

  // Read-modify-write of the bin count
  assign evt_wr    = s1_adv && s1_r.is_event;
  assign cur_count = fwd_hit_r ? fwd_data_r : rd_data;
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

  assign ram_we    = clearing_r || evt_wr;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_r.addr;
  assign ram_wdata = clearing_r ? '0 : inc_count;

  evih_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  always_comb begin
    out_nxt.bin_count       = s1_r.is_read  ? cur_count :
                              s1_r.is_event ? inc_count : '0;
    out_nxt.closed_interval = s1_r.is_event ? s1_r.addr : '0;
    out_nxt.interval_closed = s1_r.is_event;
    out_nxt.longest         = s1_r.longest;
    out_nxt.shortest        = s1_r.shortest;
    out_nxt.event_total     = s1_r.total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      gap_r       <= '0;
      longest_r   <= '0;
      shortest_r  <= TOP_BIN;
      total_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == TOP_BIN) begin
          clearing_r <= 1'b0;
        end
      end
      gap_r      <= gap_nxt;
      longest_r  <= longest_nxt;
      shortest_r <= shortest_nxt;
      total_r    <= total_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r       <= s1_nxt;
      fwd_hit_r  <= evt_wr && (s1_r.addr == in_addr);
      fwd_data_r <= inc_count;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.interval_closed;
  assign out_tdata  = {{(OUT_DATA_W - 2*COUNT_BITS - 3*BIN_W){1'b0}},
                       out_r.event_total, out_r.shortest, out_r.longest,
                       out_r.closed_interval, out_r.bin_count};

endmodule

`default_nettype wire

// ===== hdl/evih_checker.sv =====
// Port-level checker for the event interval histogram, bound to the top level.
// Depends on evih_pkg and event_interval_histogram_top.
`default_nettype none

module evih_checker
  import evih_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // Histogram sweep keeps the input closed right after reset
  a_sweep_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready && !out_tvalid)
    else $error("input open or output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[26:16] == '0)
    else $error("interval reported without a closing event");

  a_event_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:0] != '0 && out_tdata[64:49] != '0)
    else $error("closing event with zero bin count or event total");

endmodule

bind event_interval_histogram_top evih_checker u_evih_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
